>>> hw/rtl/rrs_pkg.sv
// rrs_pkg: shared types and constants of the running return statistics block
// used by the top level, the divider and the port checker

package rrs_pkg;

  localparam logic [47:0] ONE_Q16 = 48'd65536;
  localparam logic [47:0] W48_MAX = 48'hFFFF_FFFF_FFFF;

  // shared divider geometry
  localparam int DIV_N  = 96;
  localparam int DIV_D  = 50;
  localparam int DIV_CW = 7;

  // result item layout
  localparam int OUT_BITS = 328;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_WINDOW = 2'd1,
    CFG_DECAY  = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_index_t;

  localparam logic [1:0] MODE_ALL     = 2'd0;
  localparam logic [1:0] MODE_ROLLING = 2'd1;
  localparam logic [1:0] MODE_DECAY   = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] steps;
  } div_req_t;

  function automatic logic [47:0] add_one48(input logic [47:0] v);
    add_one48 = (v > (W48_MAX - ONE_Q16)) ? W48_MAX : v + ONE_Q16;
  endfunction

endpackage

>>> hw/rtl/rrs_ram.sv
// rrs_ram: generic single-write, single-read memory with registered read data
// no dependencies

module rrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/rrs_div.sv
// rrs_div: restoring divider, one quotient bit per cycle
// depends on rrs_pkg; dividend comes in left-aligned, quotient lands in the low bits

module rrs_div import rrs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  input  logic [DIV_N-1:0] dividend,
  input  logic [DIV_D-1:0] divisor,
  output logic             done,
  output logic [DIV_N-1:0] quotient
);

  logic [DIV_N-1:0]  dvd;
  logic [DIV_D-1:0]  rem;
  logic [DIV_D-1:0]  dsr;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DIV_D:0]    rem_sh;
  logic [DIV_D:0]    rem_sub;
  logic              ge;

  assign rem_sh  = {rem, dvd[DIV_N-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign ge      = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DIV_N-2:0], ge};
      rem <= ge ? rem_sub[DIV_D-1:0] : rem_sh[DIV_D-1:0];
    end
  end

  assign quotient = dvd;

endmodule

>>> hw/rtl/running_return_statistics.sv
// running_return_statistics: top level of the running return statistics block
// depends on rrs_pkg, rrs_ram (sample ring) and rrs_div (shared divider)

// Takes one signed Q16.16 return per item and answers with one snapshot item.
// The block works on one item at a time and drops s_tready while busy; a
// finished snapshot sits in the output register while the next item is taken.
// Per item: an update pass, then deviation and the three fractions, all set
// by the one-bit-per-cycle divider (49, 96 and 3 x 64 steps) and the
// 32-step square root. In rolling mode the sums are rebuilt from the ring,
// one kept sample at a time, for up to a full window of 128; decay mode adds
// a decay pass over the five sums.
// Configuration may only be written while the block is idle.

module running_return_statistics import rrs_pkg::*; #(
  parameter int WINDOW_MAX  = 128,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // return_sample
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // lifetime_total, win_run, loss_run, longest_win_run, longest_loss_run,
  // weight_total, mean, deviation, win_fraction, even_fraction,
  // loss_fraction
  output logic [OUT_BITS-1:0]                   m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [16:0]                           cfg_data
);

  localparam int HW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FW = $clog2(WINDOW_MAX + 1);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_RREQ  = 17'h00002,
    S_RLOAD = 17'h00004,
    S_DSC0  = 17'h00008,
    S_DSC1  = 17'h00010,
    S_DSC2  = 17'h00020,
    S_ACC0  = 17'h00040,
    S_ACC1  = 17'h00080,
    S_ACC2  = 17'h00100,
    S_ACC3  = 17'h00200,
    S_ACC4  = 17'h00400,
    S_STD0  = 17'h00800,
    S_STD1  = 17'h01000,
    S_SQRT  = 17'h02000,
    S_FRAC  = 17'h04000,
    S_FRW   = 17'h08000,
    S_OUT   = 17'h10000
  } state_t;

  state_t state;

  // configuration
  logic [1:0]  history_mode;
  logic [7:0]  window_length;
  logic [16:0] decay_factor;

  // run counters
  logic [31:0] seen_total, cur_win_run, cur_loss_run, best_win_run, best_loss_run;

  // sums
  logic [47:0] weight_sum, pos_weight, even_weight, lose_weight;
  logic [31:0] running_mean;
  logic [63:0] sq_dev_sum;

  // ring
  logic [HW-1:0] ring_head, pos;
  logic [FW-1:0] ring_fill, cnt;
  logic          rolling;
  logic [31:0]   ram_rdata;
  logic          ram_we;

  // working registers
  logic [31:0]  x_cur;
  logic [32:0]  delta, mag_a, mag_b;
  logic [2:0]   k;
  logic [16:0]  fac;
  logic [49:0]  acc;
  logic [64:0]  prod;
  logic [63:0]  sq_v, sq_r, sq_bit;
  logic [5:0]   sq_cnt;
  logic [31:0]  dev;
  logic [1:0]   fk;
  logic [16:0]  fr_win, fr_even, fr_loss;

  // shared multiplier operands
  logic [47:0]  mul_x;
  logic [16:0]  mul_y;

  // shared divider
  div_req_t         div_req;
  logic [DIV_N-1:0] div_dividend, div_q;
  logic [DIV_D-1:0] div_divisor;
  logic             div_done;

  // input conditioning
  logic [63:0] sext;
  logic [31:0] x_sat;
  assign sext  = 64'($signed(s_tdata[SAMPLE_BITS-1:0]));
  assign x_sat = ($signed(sext) > 64'sd2147483647)  ? 32'h7FFF_FFFF :
                 ($signed(sext) < -64'sd2147483648) ? 32'h8000_0000 : sext[31:0];

  logic accept;
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // window bookkeeping
  logic [31:0]   len32, fill32, pos32;
  logic [HW-1:0] head_next;
  logic [FW-1:0] fill_next;
  always_comb begin
    len32 = (window_length == 8'd0) ? 32'd1 : 32'(window_length);
    if (len32 > 32'(WINDOW_MAX)) begin
      len32 = 32'(WINDOW_MAX);
    end
    head_next = (32'(ring_head) == 32'(WINDOW_MAX - 1)) ? '0 : ring_head + 1'b1;
    fill32 = 32'(ring_fill) + 32'd1;
    if (fill32 > len32) begin
      fill32 = len32;
    end
    fill_next = FW'(fill32);
    pos32 = 32'(head_next) + 32'(WINDOW_MAX) - fill32;
    if (pos32 >= 32'(WINDOW_MAX)) begin
      pos32 = pos32 - 32'(WINDOW_MAX);
    end
  end

  logic [HW-1:0] pos_inc;
  assign pos_inc = (32'(pos) == 32'(WINDOW_MAX - 1)) ? '0 : pos + 1'b1;

  logic [16:0] fac_in;
  assign fac_in = (decay_factor > 17'd65536) ? 17'd65536 : decay_factor;

  // value under decay
  logic [63:0] dv;
  always_comb begin
    case (k)
      3'd0:    dv = 64'(weight_sum);
      3'd1:    dv = sq_dev_sum;
      3'd2:    dv = 64'(pos_weight);
      3'd3:    dv = 64'(even_weight);
      default: dv = 64'(lose_weight);
    endcase
  end

  always_comb begin
    case (state)
      S_DSC0:  begin mul_x = {32'd0, dv[15:0]}; mul_y = fac; end
      S_DSC1:  begin mul_x = dv[63:16];          mul_y = fac; end
      S_ACC2:  begin mul_x = 48'(mag_a);         mul_y = {1'b0, mag_b[15:0]}; end
      S_ACC3:  begin mul_x = 48'(mag_a);         mul_y = mag_b[32:16]; end
      default: begin mul_x = '0;                 mul_y = '0; end
    endcase
  end

  // accumulate arithmetic
  logic [47:0] weight_inc;
  logic [32:0] delta_now, delta_mag;
  assign weight_inc = add_one48(weight_sum);
  assign delta_now  = {x_cur[31], x_cur} - {running_mean[31], running_mean};
  assign delta_mag  = delta_now[32] ? -delta_now : delta_now;

  logic [34:0] step, mean_sum;
  logic [31:0] mean_new;
  logic [32:0] after;
  assign step     = delta[32] ? -{1'b0, div_q[33:0]} : {1'b0, div_q[33:0]};
  assign mean_sum = {{3{running_mean[31]}}, running_mean} + step;
  assign mean_new = mean_sum[31:0];
  assign after    = {x_cur[31], x_cur} - {mean_new[31], mean_new};

  logic [50:0] inc;
  logic [64:0] sq_add;
  logic [63:0] dsc_res;
  assign inc     = {1'b0, prod[49:0]} + 51'(acc);
  assign sq_add  = {1'b0, sq_dev_sum} + 65'(inc);
  assign dsc_res = prod[63:0] + 64'(acc);

  logic [49:0] total;
  logic [47:0] part;
  assign total = 50'(pos_weight) + 50'(even_weight) + 50'(lose_weight);
  always_comb begin
    case (fk)
      2'd0:    part = pos_weight;
      2'd1:    part = even_weight;
      default: part = lose_weight;
    endcase
  end

  logic [63:0] sq_try;
  assign sq_try = sq_r + sq_bit;

  always_comb begin
    div_req      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_ACC0: begin
        div_req.start = 1'b1;
        div_req.steps = DIV_CW'(49);
        div_dividend  = {delta_mag, 63'd0};
        div_divisor   = DIV_D'(weight_inc);
      end
      S_STD0: begin
        div_req.start = (weight_sum > ONE_Q16);
        div_req.steps = DIV_CW'(96);
        div_dividend  = {sq_dev_sum, 32'd0};
        div_divisor   = DIV_D'(weight_sum - ONE_Q16);
      end
      S_FRAC: begin
        div_req.start = (total != '0);
        div_req.steps = DIV_CW'(64);
        div_dividend  = {part, 48'd0};
        div_divisor   = total;
      end
      default: ;
    endcase
  end

  rrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign ram_we = accept && (history_mode == MODE_ROLLING);

  rrs_ram #(.WIDTH(32), .DEPTH(WINDOW_MAX)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_head),
    .wdata (x_sat),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      history_mode  <= MODE_ALL;
      window_length <= 8'd100;
      decay_factor  <= 17'd64881;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   history_mode  <= cfg_data[1:0];
        CFG_WINDOW: window_length <= cfg_data[7:0];
        CFG_DECAY:  decay_factor  <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    prod <= {17'd0, mul_x} * {48'd0, mul_y};
    case (state)
      S_IDLE:  x_cur <= x_sat;
      S_RLOAD: x_cur <= ram_rdata;
      S_DSC1:  acc <= 50'(prod[32:16]);
      S_ACC0:  delta <= delta_now;
      S_ACC1: begin
        mag_a <= delta[32] ? -delta : delta;
        mag_b <= after[32] ? -after : after;
      end
      S_ACC3:  acc <= 50'(prod[49:16]);
      S_STD1: begin
        sq_v   <= (div_q[95:64] != '0) ? '1 : div_q[63:0];
        sq_r   <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
        sq_cnt <= '0;
      end
      S_SQRT: begin
        if (sq_v >= sq_try) begin
          sq_v <= sq_v - sq_try;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt + 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      seen_total    <= '0;
      cur_win_run   <= '0;
      cur_loss_run  <= '0;
      best_win_run  <= '0;
      best_loss_run <= '0;
      ring_head     <= '0;
      ring_fill     <= '0;
      pos           <= '0;
      cnt           <= '0;
      rolling       <= 1'b0;
      weight_sum    <= '0;
      running_mean  <= '0;
      sq_dev_sum    <= '0;
      pos_weight    <= '0;
      even_weight   <= '0;
      lose_weight   <= '0;
      k             <= '0;
      fk            <= '0;
      fac           <= '0;
    end else begin
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            seen_total <= (seen_total == '1) ? seen_total : seen_total + 1'b1;
            if (!x_sat[31] && x_sat != '0) begin
              cur_win_run  <= (cur_win_run == '1) ? cur_win_run : cur_win_run + 1'b1;
              cur_loss_run <= '0;
              if (cur_win_run != '1 && cur_win_run + 1'b1 > best_win_run) begin
                best_win_run <= cur_win_run + 1'b1;
              end
            end else if (x_sat[31]) begin
              cur_win_run  <= '0;
              cur_loss_run <= (cur_loss_run == '1) ? cur_loss_run : cur_loss_run + 1'b1;
              if (cur_loss_run != '1 && cur_loss_run + 1'b1 > best_loss_run) begin
                best_loss_run <= cur_loss_run + 1'b1;
              end
            end else begin
              cur_win_run  <= '0;
              cur_loss_run <= '0;
            end
            rolling <= 1'b0;
            case (history_mode)
              MODE_ROLLING: begin
                rolling      <= 1'b1;
                ring_head    <= head_next;
                ring_fill    <= fill_next;
                cnt          <= fill_next;
                pos          <= HW'(pos32);
                weight_sum   <= '0;
                running_mean <= '0;
                sq_dev_sum   <= '0;
                pos_weight   <= '0;
                even_weight  <= '0;
                lose_weight  <= '0;
                state        <= S_RREQ;
              end
              MODE_DECAY: begin
                k     <= '0;
                fac   <= fac_in;
                state <= S_DSC0;
              end
              default: state <= S_ACC0;
            endcase
          end
        end
        S_RREQ:  state <= S_RLOAD;
        S_RLOAD: state <= S_ACC0;
        S_DSC0:  state <= S_DSC1;
        S_DSC1:  state <= S_DSC2;
        S_DSC2: begin
          case (k)
            3'd0:    weight_sum  <= dsc_res[47:0];
            3'd1:    sq_dev_sum  <= dsc_res;
            3'd2:    pos_weight  <= dsc_res[47:0];
            3'd3:    even_weight <= dsc_res[47:0];
            default: ;
          endcase
          if (k == 3'd4) begin
            // weight decayed to nothing: start over, mean included
            if (weight_sum == '0) begin
              running_mean <= '0;
              sq_dev_sum   <= '0;
              pos_weight   <= '0;
              even_weight  <= '0;
              lose_weight  <= '0;
            end else begin
              lose_weight  <= dsc_res[47:0];
            end
            state <= S_ACC0;
          end else begin
            k     <= k + 1'b1;
            state <= S_DSC0;
          end
        end
        S_ACC0: begin
          weight_sum <= weight_inc;
          state      <= S_ACC1;
        end
        S_ACC1: begin
          if (div_done) begin
            running_mean <= mean_new;
            state        <= S_ACC2;
          end
        end
        S_ACC2: state <= S_ACC3;
        S_ACC3: state <= S_ACC4;
        S_ACC4: begin
          sq_dev_sum <= sq_add[64] ? '1 : sq_add[63:0];
          if (!x_cur[31] && x_cur != '0) begin
            pos_weight <= add_one48(pos_weight);
          end else if (x_cur[31]) begin
            lose_weight <= add_one48(lose_weight);
          end else begin
            even_weight <= add_one48(even_weight);
          end
          if (rolling && cnt > FW'(1)) begin
            cnt   <= cnt - 1'b1;
            pos   <= pos_inc;
            state <= S_RREQ;
          end else begin
            state <= S_STD0;
          end
        end
        S_STD0: begin
          if (weight_sum > ONE_Q16) begin
            state <= S_STD1;
          end else begin
            fk    <= '0;
            state <= S_FRAC;
          end
        end
        S_STD1: begin
          if (div_done) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_cnt == 6'd31) begin
            fk    <= '0;
            state <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (total == '0) begin
            fr_win  <= '0;
            fr_even <= '0;
            fr_loss <= '0;
            state   <= S_OUT;
          end else begin
            state <= S_FRW;
          end
        end
        S_FRW: begin
          if (div_done) begin
            case (fk)
              2'd0:    fr_win  <= div_q[16:0];
              2'd1:    fr_even <= div_q[16:0];
              default: fr_loss <= div_q[16:0];
            endcase
            if (fk == 2'd2) begin
              state <= S_OUT;
            end else begin
              fk    <= fk + 1'b1;
              state <= S_FRAC;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // deviation register: cleared path or square root result
  always_ff @(posedge clk) begin
    if (state == S_STD0 && !(weight_sum > ONE_Q16)) begin
      dev <= '0;
    end else if (state == S_SQRT && sq_cnt == 6'd31) begin
      dev <= (sq_v >= sq_try) ? 32'((sq_r >> 1) + sq_bit) : 32'(sq_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'd0, fr_loss, fr_even, fr_win, dev, running_mean, weight_sum,
                  best_loss_run, best_win_run, cur_loss_run, cur_win_run, seen_total};
    end
  end

endmodule

>>> hw/rtl/rrs_checker.sv
// rrs_checker: port-level checks of the running return statistics block
// depends on rrs_pkg; bound to the top level at the end of this file

module rrs_checker import rrs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_BITS-1:0] m_tdata
);

  // no result item right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result item valid after reset");

  // a held result item keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // an accepted item keeps the block busy for the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  // win and loss runs never run at once
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:32] == '0 || m_tdata[95:64] == '0))
    else $error("win and loss runs both nonzero");

  // longest runs cover the current runs
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[127:96] >= m_tdata[63:32] && m_tdata[159:128] >= m_tdata[95:64]))
    else $error("current run beyond longest run");

endmodule

bind running_return_statistics rrs_checker u_rrs_checker (.*);
